### src/fhv_pkg.sv
`timescale 1ns / 1ps

package fhv_pkg;

  localparam int F1_BITS_DEF       = 4;
  localparam int BLOCK_ENTRIES_DEF = 8;
  localparam int POOL_BLOCKS_DEF   = 4096;
  localparam int ID_BITS_DEF       = 5;
  localparam int TOFF_BITS_DEF     = 12;

  localparam int DF_BITS    = 6;
  localparam int DT_BITS    = 6;
  localparam int LEN_W      = 16;
  localparam int SCORE_W    = 16;
  localparam logic [LEN_W-1:0]   LENGTH_MAX = 16'hFFFF;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 16'd32767;

  localparam logic [2:0] CFG_ADDR_SONG_COUNT = 3'd0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_VOTE   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_RANGE    = 2'd1,
    ST_POOLFULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_BKT,
    S_PRD,
    S_PDAT,
    S_VDAT,
    S_STEP,
    S_LNK,
    S_CLR,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

### src/fhv_if.sv
`timescale 1ns / 1ps

interface fhv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  freq_bin;
  logic [5:0]  freq_delta;
  logic [5:0]  time_delta;
  logic [15:0] song_id;
  logic [15:0] time_offset;

  modport source (
    output valid, operation, freq_bin, freq_delta, time_delta, song_id, time_offset,
    input  ready
  );
  modport sink (
    input  valid, operation, freq_bin, freq_delta, time_delta, song_id, time_offset,
    output ready
  );
endinterface

interface fhv_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [4:0]  best_song;
  logic        [11:0] best_offset;
  logic signed [15:0] best_score;

  modport source (output valid, status, best_song, best_offset, best_score, input ready);
  modport sink   (input valid, status, best_song, best_offset, best_score, output ready);
endinterface

### src/fhv_ram.sv
`timescale 1ns / 1ps

module fhv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/fingerprint_hash_index_voting.sv
`timescale 1ns / 1ps

// Landmark hash index with offset voting. One transaction at a time; every
// transaction returns exactly one result. After reset the block sweeps the
// bucket table and vote table to zero, one entry per cycle, before it takes
// a transaction. Vote goes straight to its result on an empty bucket, else
// it walks the bucket's entries with a single-port pool read for each,
// followed by a read-modify-write of the vote counter for each entry that
// casts a vote, and with a link read to step from one block to the next.
// Clear writes the whole vote table to zero, one vote table write per
// cycle. Read scans rows*2^TOFF_BITS counters, one vote table read per
// cycle, where rows is min(song_count, 2^ID_BITS); when rows is zero it
// goes straight to its result.
module fingerprint_hash_index_voting
  import fhv_pkg::*;
#(
  parameter int F1_BITS       = F1_BITS_DEF,
  parameter int BLOCK_ENTRIES = BLOCK_ENTRIES_DEF,
  parameter int POOL_BLOCKS   = POOL_BLOCKS_DEF,
  parameter int ID_BITS       = ID_BITS_DEF,
  parameter int TOFF_BITS     = TOFF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fhv_in_if.sink      in_ch,
  fhv_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int KEY_W      = F1_BITS + DF_BITS + DT_BITS;
  localparam int KEY_DEPTH  = 1 << KEY_W;
  localparam int BLK_W      = $clog2(POOL_BLOCKS);
  localparam int BU_W       = $clog2(POOL_BLOCKS + 1);
  localparam int FILL_W     = $clog2(BLOCK_ENTRIES + 1);
  localparam int BKT_W      = LEN_W + BLK_W + FILL_W;
  localparam int POOL_DEPTH = POOL_BLOCKS * BLOCK_ENTRIES;
  localparam int PA_W       = $clog2(POOL_DEPTH);
  localparam int ENT_W      = ID_BITS + TOFF_BITS;
  localparam int VOTE_AW    = ID_BITS + TOFF_BITS;
  localparam int VOTE_DEPTH = 1 << VOTE_AW;
  localparam int SONG_ROWS  = 1 << ID_BITS;
  localparam int CLR_W      = (KEY_W > VOTE_AW) ? KEY_W : VOTE_AW;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [15:0]            id_r, id_nxt;
  logic [15:0]            off_r, off_nxt;
  logic [CLR_W-1:0]       cnt_r, cnt_nxt;
  logic [LEN_W-1:0]       rem_r, rem_nxt;
  logic [FILL_W-1:0]      k_r, k_nxt;
  logic [BLK_W-1:0]       blk_r, blk_nxt;
  logic [VOTE_AW-1:0]     vidx_r, vidx_nxt;
  logic [VOTE_AW-1:0]     scan_addr_r, scan_addr_nxt;
  logic [VOTE_AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic                   scan_end_r, scan_end_nxt;
  logic                   pend_r, pend_nxt;
  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic [ID_BITS-1:0]     bsong_r, bsong_nxt;
  logic [TOFF_BITS-1:0]   boff_r, boff_nxt;
  logic [1:0]             res_status_r, res_status_nxt;
  logic [BU_W-1:0]        blocks_used_r, blocks_used_nxt;
  logic [5:0]             song_count_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic [4:0]                out_song_r, out_song_nxt;
  logic [11:0]               out_offset_r, out_offset_nxt;
  logic signed [SCORE_W-1:0] out_score_r, out_score_nxt;

  // memory ports
  logic                 bkt_we;
  logic [KEY_W-1:0]     bkt_addr;
  logic [BKT_W-1:0]     bkt_wdata, bkt_rdata;
  logic                 lnk_we;
  logic [BLK_W-1:0]     lnk_addr, lnk_wdata, lnk_rdata;
  logic                 pool_we;
  logic [PA_W-1:0]      pool_addr;
  logic [ENT_W-1:0]     pool_wdata, pool_rdata;
  logic                 vote_we;
  logic [VOTE_AW-1:0]   vote_addr;
  logic [SCORE_W-1:0]   vote_wdata, vote_rdata;

  fhv_ram #(.WIDTH(BKT_W), .DEPTH(KEY_DEPTH)) u_bkt_ram (
    .clk, .we(bkt_we), .addr(bkt_addr), .wdata(bkt_wdata), .rdata(bkt_rdata)
  );
  fhv_ram #(.WIDTH(BLK_W), .DEPTH(POOL_BLOCKS)) u_lnk_ram (
    .clk, .we(lnk_we), .addr(lnk_addr), .wdata(lnk_wdata), .rdata(lnk_rdata)
  );
  fhv_ram #(.WIDTH(ENT_W), .DEPTH(POOL_DEPTH)) u_pool_ram (
    .clk, .we(pool_we), .addr(pool_addr), .wdata(pool_wdata), .rdata(pool_rdata)
  );
  fhv_ram #(.WIDTH(SCORE_W), .DEPTH(VOTE_DEPTH)) u_vote_ram (
    .clk, .we(vote_we), .addr(vote_addr), .wdata(vote_wdata), .rdata(vote_rdata)
  );

  // bucket word: length, head block, entries in head block
  logic [LEN_W-1:0]  b_len;
  logic [BLK_W-1:0]  b_head;
  logic [FILL_W-1:0] b_fill;
  assign {b_len, b_head, b_fill} = bkt_rdata;

  logic [ID_BITS:0]     rows;
  logic [ID_BITS-1:0]   rows_m1;
  logic [KEY_W-1:0]     in_key;
  logic                 in_accept;
  logic [TOFF_BITS-1:0] p_stored;
  logic [ID_BITS-1:0]   p_song;
  logic                 need_blk;
  logic [BLK_W-1:0]     new_head;
  logic [FILL_W-1:0]    new_fill;
  logic [PA_W-1:0]      new_slot;

  assign rows = (32'(song_count_r) < SONG_ROWS) ? (ID_BITS+1)'(song_count_r)
                                                : (ID_BITS+1)'(SONG_ROWS);
  assign rows_m1 = ID_BITS'(rows - 1'b1);
  assign in_key = {F1_BITS'(in_ch.freq_bin), in_ch.freq_delta, in_ch.time_delta};
  assign in_accept = in_ch.valid && in_ch.ready;
  assign p_stored = pool_rdata[TOFF_BITS-1:0];
  assign p_song = pool_rdata[ENT_W-1:TOFF_BITS];

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.best_song = out_song_r;
  assign out_ch.best_offset = out_offset_r;
  assign out_ch.best_score = out_score_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_SONG_COUNT) ? {26'd0, song_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      song_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == CFG_ADDR_SONG_COUNT) begin
      song_count_r <= cfg_pwdata[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      cnt_r         <= '0;
      blocks_used_r <= '0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
      scan_end_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      blocks_used_r <= blocks_used_nxt;
      out_valid_r   <= out_valid_nxt;
      pend_r        <= pend_nxt;
      scan_end_r    <= scan_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    id_r         <= id_nxt;
    off_r        <= off_nxt;
    rem_r        <= rem_nxt;
    k_r          <= k_nxt;
    blk_r        <= blk_nxt;
    vidx_r       <= vidx_nxt;
    scan_addr_r  <= scan_addr_nxt;
    pend_addr_r  <= pend_addr_nxt;
    best_r       <= best_nxt;
    bsong_r      <= bsong_nxt;
    boff_r       <= boff_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_song_r   <= out_song_nxt;
    out_offset_r <= out_offset_nxt;
    out_score_r  <= out_score_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    id_nxt          = id_r;
    off_nxt         = off_r;
    cnt_nxt         = cnt_r;
    rem_nxt         = rem_r;
    k_nxt           = k_r;
    blk_nxt         = blk_r;
    vidx_nxt        = vidx_r;
    scan_addr_nxt   = scan_addr_r;
    pend_addr_nxt   = pend_addr_r;
    scan_end_nxt    = scan_end_r;
    pend_nxt        = 1'b0;
    best_nxt        = best_r;
    bsong_nxt       = bsong_r;
    boff_nxt        = boff_r;
    res_status_nxt  = res_status_r;
    blocks_used_nxt = blocks_used_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_song_nxt    = out_song_r;
    out_offset_nxt  = out_offset_r;
    out_score_nxt   = out_score_r;

    bkt_we     = 1'b0;
    bkt_addr   = key_r;
    bkt_wdata  = '0;
    lnk_we     = 1'b0;
    lnk_addr   = blk_r;
    lnk_wdata  = b_head;
    pool_we    = 1'b0;
    pool_addr  = PA_W'(blk_r) * PA_W'(BLOCK_ENTRIES) + PA_W'(k_r - 1'b1);
    pool_wdata = {id_r[ID_BITS-1:0], off_r[TOFF_BITS-1:0]};
    vote_we    = 1'b0;
    vote_addr  = vidx_r;
    vote_wdata = '0;

    need_blk = (b_len == '0) || (32'(b_fill) == BLOCK_ENTRIES);
    new_head = need_blk ? blocks_used_r[BLK_W-1:0] : b_head;
    new_fill = need_blk ? FILL_W'(1) : FILL_W'(b_fill + 1'b1);
    new_slot = need_blk ? '0 : PA_W'(b_fill);

    unique case (state_r)
      S_INIT: begin
        bkt_addr  = cnt_r[KEY_W-1:0];
        bkt_we    = {1'b0, cnt_r} < (CLR_W+1)'(KEY_DEPTH);
        vote_addr = cnt_r[VOTE_AW-1:0];
        vote_we   = {1'b0, cnt_r} < (CLR_W+1)'(VOTE_DEPTH);
        cnt_nxt   = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        bkt_addr = in_key;
        if (in_accept) begin
          op_nxt         = op_t'(in_ch.operation);
          key_nxt        = in_key;
          id_nxt         = in_ch.song_id;
          off_nxt        = in_ch.time_offset;
          res_status_nxt = ST_DONE;
          best_nxt       = -16'sd1;
          bsong_nxt      = '0;
          boff_nxt       = '0;
          cnt_nxt        = '0;
          scan_addr_nxt  = '0;
          scan_end_nxt   = 1'b0;
          unique case (op_t'(in_ch.operation))
            OP_INSERT, OP_VOTE: state_nxt = S_BKT;
            OP_CLEAR:           state_nxt = S_CLR;
            OP_READ:            state_nxt = (rows == '0) ? S_DONE : S_SCAN;
          endcase
        end
      end

      S_BKT: begin
        if (op_r == OP_INSERT) begin
          priority if (id_r[15:ID_BITS] != '0 ||
                       {1'b0, off_r} > 17'((1 << TOFF_BITS) - 1)) begin
            res_status_nxt = ST_RANGE;
          end else if (b_len >= LENGTH_MAX) begin
            res_status_nxt = ST_POOLFULL;
          end else if (need_blk && blocks_used_r >= BU_W'(POOL_BLOCKS)) begin
            res_status_nxt = ST_POOLFULL;
          end else begin
            if (need_blk) begin
              // new block goes to the head, old head becomes its successor
              lnk_we          = 1'b1;
              lnk_addr        = blocks_used_r[BLK_W-1:0];
              blocks_used_nxt = blocks_used_r + 1'b1;
            end
            pool_we   = 1'b1;
            pool_addr = PA_W'(new_head) * PA_W'(BLOCK_ENTRIES) + new_slot;
            bkt_we    = 1'b1;
            bkt_wdata = {LEN_W'(b_len + 1'b1), new_head, new_fill};
          end
          state_nxt = S_DONE;
        end else begin
          if (b_len == '0) begin
            state_nxt = S_DONE;
          end else begin
            rem_nxt   = b_len;
            blk_nxt   = b_head;
            k_nxt     = b_fill;
            state_nxt = S_PRD;
          end
        end
      end

      S_PRD: begin
        state_nxt = S_PDAT;
      end

      S_PDAT: begin
        if (32'(p_stored) >= 32'(off_r) && (ID_BITS+1)'(p_song) < rows) begin
          vidx_nxt  = {p_song, TOFF_BITS'(p_stored - off_r[TOFF_BITS-1:0])};
          vote_addr = {p_song, TOFF_BITS'(p_stored - off_r[TOFF_BITS-1:0])};
          state_nxt = S_VDAT;
        end else begin
          state_nxt = S_STEP;
        end
      end

      S_VDAT: begin
        vote_we    = 1'b1;
        vote_wdata = (vote_rdata < SCORE_MAX) ? vote_rdata + 1'b1 : vote_rdata;
        state_nxt  = S_STEP;
      end

      S_STEP: begin
        rem_nxt = rem_r - 1'b1;
        if (rem_r == LEN_W'(1)) begin
          state_nxt = S_DONE;
        end else if (k_r == FILL_W'(1)) begin
          // link read issued here, data arrives in the link state
          k_nxt     = FILL_W'(BLOCK_ENTRIES);
          state_nxt = S_LNK;
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_PRD;
        end
      end

      S_LNK: begin
        blk_nxt   = lnk_rdata;
        state_nxt = S_PRD;
      end

      S_CLR: begin
        vote_addr = cnt_r[VOTE_AW-1:0];
        vote_we   = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CLR_W'(VOTE_DEPTH - 1)) begin
          state_nxt = S_DONE;
        end
      end

      S_SCAN: begin
        vote_addr = scan_addr_r;
        if (!scan_end_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = scan_addr_r;
          if (scan_addr_r[VOTE_AW-1:TOFF_BITS] == rows_m1 &&
              &scan_addr_r[TOFF_BITS-1:0]) begin
            scan_end_nxt = 1'b1;
          end else begin
            scan_addr_nxt = scan_addr_r + 1'b1;
          end
        end
        if (pend_r && $signed(vote_rdata) > best_r) begin
          best_nxt  = $signed(vote_rdata);
          bsong_nxt = pend_addr_r[VOTE_AW-1:TOFF_BITS];
          boff_nxt  = pend_addr_r[TOFF_BITS-1:0];
        end
        if (scan_end_r && !pend_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          if (op_r == OP_READ) begin
            out_song_nxt   = 5'(bsong_r);
            out_offset_nxt = 12'(boff_r);
            out_score_nxt  = best_r;
          end else begin
            out_song_nxt   = '0;
            out_offset_nxt = '0;
            out_score_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_INIT;
    endcase
  end

`ifndef ASSERT_OFF
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    blocks_used_r <= BU_W'(POOL_BLOCKS))
    else $error("block pool count past its size");

  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VDAT |-> $past(state_r) == S_PDAT)
    else $error("counter write without a preceding counter read");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside completion");

  a_insert_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_r != OP_INSERT) |-> res_status_r == ST_DONE)
    else $error("nonzero status on a non-insert transaction");
`endif

endmodule
